>>> hdl/mctg_pkg.sv
// ----------------------------------------------------------------------------
// mctg_pkg
// Shared types, constants and the control program of the MIDI beat clock
// transport generator.
// ----------------------------------------------------------------------------
package mctg_pkg;

   // Field widths of the channels
   localparam int CMD_W      = 3;
   localparam int COUNT_W    = 11;
   localparam int LOC_W      = 20;
   localparam int BYTE_W     = 8;
   localparam int STATE_W    = 2;
   localparam int SONG_W     = 48;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // Register widths
   localparam int TEMPO_W = 20;
   localparam int RATE_W  = 18;
   localparam int POS_W   = 64;

   // Fraction bits of the locate field and of the reported position
   localparam int LOC_FRAC  = 8;
   localparam int SONG_FRAC = 24;

   // 60000 * rate fits in 16 + 18 bits
   localparam int MPM_W = 16;
   localparam int DEN_W = MPM_W + RATE_W;

   localparam logic [MPM_W-1:0]   MILLI_PER_MINUTE = 16'd60000;
   localparam logic [TEMPO_W-1:0] TEMPO_MIN   = 20'd20000;
   localparam logic [TEMPO_W-1:0] TEMPO_MAX   = 20'd999000;
   localparam logic [TEMPO_W-1:0] TEMPO_RESET = 20'd120000;
   localparam logic [RATE_W-1:0]  RATE_MIN    = 18'd8000;
   localparam logic [RATE_W-1:0]  RATE_MAX    = 18'd192000;
   localparam logic [RATE_W-1:0]  RATE_RESET  = 18'd48000;

   // Clock bytes per advance are capped
   localparam int PCNT_W = 7;
   localparam logic [PCNT_W-1:0] MAX_PULSES = 7'd64;

   // MIDI bytes
   localparam logic [BYTE_W-1:0] MIDI_CLOCK = 8'hF8;
   localparam logic [BYTE_W-1:0] MIDI_START = 8'hFA;
   localparam logic [BYTE_W-1:0] MIDI_STOP  = 8'hFC;
   localparam logic [BYTE_W-1:0] MIDI_SPP   = 8'hF2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PLAY    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PAUSE   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RECORD  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_LOCATE  = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TEMPO  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RATE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CLK_EN = 2'd2;

   typedef enum logic [STATE_W-1:0] {
      MODE_STOPPED   = 2'd0,
      MODE_PLAYING   = 2'd1,
      MODE_PAUSED    = 2'd2,
      MODE_RECORDING = 2'd3
   } mode_type;

   // Datapath action of one step
   typedef enum logic [3:0] {
      ACT_NONE   = 4'd0,
      ACT_ACCEPT = 4'd1,
      ACT_MUL    = 4'd2,
      ACT_LOAD   = 4'd3,
      ACT_DIV    = 4'd4,
      ACT_ACC    = 4'd5,
      ACT_PLAY   = 4'd6,
      ACT_STOP   = 4'd7,
      ACT_PAUSE  = 4'd8,
      ACT_RECORD = 4'd9,
      ACT_LOCATE = 4'd10
   } act_type;

   // Result written by one step
   typedef enum logic [2:0] {
      EM_NONE   = 3'd0,
      EM_STATUS = 3'd1,
      EM_CLOCK  = 3'd2,
      EM_START  = 3'd3,
      EM_STOP   = 3'd4,
      EM_SPP    = 3'd5,
      EM_SPP_LO = 3'd6,
      EM_SPP_HI = 3'd7
   } emit_type;

   // Jump condition; a jump not taken falls through to the next step
   typedef enum logic [3:0] {
      BR_NEXT       = 4'd0,
      BR_ALWAYS     = 4'd1,
      BR_DISPATCH   = 4'd2,
      BR_DIV_MORE   = 4'd3,
      BR_PULSE_MORE = 4'd4,
      BR_NO_PULSE   = 4'd5,
      BR_NOT_RUN    = 4'd6,
      BR_SKIP_PLAY  = 4'd7,
      BR_SKIP_STOP  = 4'd8,
      BR_NO_EN      = 4'd9
   } cond_type;

   typedef logic [4:0] upc_type;

   typedef struct packed {
      act_type  act;
      emit_type emit;
      logic     last;
      cond_type cond;
      upc_type  target;
   } ucode_type;

   // Entry points of the program
   localparam upc_type UPC_IDLE   = 5'd0;
   localparam upc_type UPC_ADV    = 5'd1;
   localparam upc_type UPC_DIV    = 5'd3;
   localparam upc_type UPC_CLOCK  = 5'd6;
   localparam upc_type UPC_PLAY   = 5'd8;
   localparam upc_type UPC_STOP   = 5'd11;
   localparam upc_type UPC_PAUSE  = 5'd14;
   localparam upc_type UPC_RECORD = 5'd16;
   localparam upc_type UPC_LOCATE = 5'd18;
   localparam upc_type UPC_STATUS = 5'd22;

   function automatic ucode_type uword(input act_type a, input emit_type e, input logic l,
                                       input cond_type c, input upc_type t);
      ucode_type w;
      w.act    = a;
      w.emit   = e;
      w.last   = l;
      w.cond   = c;
      w.target = t;
      return w;
   endfunction

   // Control store
   function automatic ucode_type ucode_rom(input upc_type addr);
      ucode_type w;
      w = uword(ACT_NONE, EM_NONE, 1'b0, BR_ALWAYS, UPC_IDLE);
      unique case (addr)
         5'd0:  w = uword(ACT_ACCEPT, EM_NONE,   1'b0, BR_DISPATCH,   UPC_IDLE);
         // advance
         5'd1:  w = uword(ACT_MUL,    EM_NONE,   1'b0, BR_NOT_RUN,    UPC_STATUS);
         5'd2:  w = uword(ACT_LOAD,   EM_NONE,   1'b0, BR_NEXT,       UPC_IDLE);
         5'd3:  w = uword(ACT_DIV,    EM_NONE,   1'b0, BR_DIV_MORE,   UPC_DIV);
         5'd4:  w = uword(ACT_ACC,    EM_NONE,   1'b0, BR_NEXT,       UPC_IDLE);
         5'd5:  w = uword(ACT_NONE,   EM_NONE,   1'b0, BR_NO_PULSE,   UPC_STATUS);
         5'd6:  w = uword(ACT_NONE,   EM_CLOCK,  1'b0, BR_PULSE_MORE, UPC_CLOCK);
         5'd7:  w = uword(ACT_NONE,   EM_NONE,   1'b0, BR_ALWAYS,     UPC_IDLE);
         // play
         5'd8:  w = uword(ACT_NONE,   EM_NONE,   1'b0, BR_SKIP_PLAY,  UPC_STATUS);
         5'd9:  w = uword(ACT_PLAY,   EM_NONE,   1'b0, BR_NO_EN,      UPC_STATUS);
         5'd10: w = uword(ACT_NONE,   EM_START,  1'b1, BR_ALWAYS,     UPC_IDLE);
         // stop
         5'd11: w = uword(ACT_NONE,   EM_NONE,   1'b0, BR_SKIP_STOP,  UPC_STATUS);
         5'd12: w = uword(ACT_STOP,   EM_NONE,   1'b0, BR_NO_EN,      UPC_STATUS);
         5'd13: w = uword(ACT_NONE,   EM_STOP,   1'b1, BR_ALWAYS,     UPC_IDLE);
         // pause
         5'd14: w = uword(ACT_PAUSE,  EM_NONE,   1'b0, BR_NO_EN,      UPC_STATUS);
         5'd15: w = uword(ACT_NONE,   EM_STOP,   1'b1, BR_ALWAYS,     UPC_IDLE);
         // record
         5'd16: w = uword(ACT_RECORD, EM_NONE,   1'b0, BR_NO_EN,      UPC_STATUS);
         5'd17: w = uword(ACT_NONE,   EM_START,  1'b1, BR_ALWAYS,     UPC_IDLE);
         // locate
         5'd18: w = uword(ACT_LOCATE, EM_NONE,   1'b0, BR_NO_EN,      UPC_STATUS);
         5'd19: w = uword(ACT_NONE,   EM_SPP,    1'b0, BR_NEXT,       UPC_IDLE);
         5'd20: w = uword(ACT_NONE,   EM_SPP_LO, 1'b0, BR_NEXT,       UPC_IDLE);
         5'd21: w = uword(ACT_NONE,   EM_SPP_HI, 1'b1, BR_ALWAYS,     UPC_IDLE);
         // status-only result
         5'd22: w = uword(ACT_NONE,   EM_STATUS, 1'b1, BR_ALWAYS,     UPC_IDLE);
         default: w = uword(ACT_NONE, EM_NONE,   1'b0, BR_ALWAYS,     UPC_IDLE);
      endcase
      return w;
   endfunction

   // Entry step of each command
   function automatic upc_type dispatch(input logic [CMD_W-1:0] cmd);
      upc_type t;
      t = UPC_STATUS;
      unique case (cmd)
         CMD_ADVANCE: t = UPC_ADV;
         CMD_PLAY:    t = UPC_PLAY;
         CMD_STOP:    t = UPC_STOP;
         CMD_PAUSE:   t = UPC_PAUSE;
         CMD_RECORD:  t = UPC_RECORD;
         CMD_LOCATE:  t = UPC_LOCATE;
         default:     t = UPC_STATUS;
      endcase
      return t;
   endfunction

endpackage

>>> hdl/mctg_if.sv
// ----------------------------------------------------------------------------
// mctg channels
// Valid/ready channels of the transport generator: commands, results and
// register writes.
// ----------------------------------------------------------------------------
interface mctg_req_if;
   import mctg_pkg::*;
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [COUNT_W-1:0] sample_count;
   logic [LOC_W-1:0]   locate_beats_q8;
   modport source(output valid, cmd, sample_count, locate_beats_q8, input ready);
   modport sink(input valid, cmd, sample_count, locate_beats_q8, output ready);
endinterface

interface mctg_rsp_if;
   import mctg_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0]  midi_byte;
   logic              byte_valid;
   logic              last;
   logic [STATE_W-1:0] transport_state;
   logic [SONG_W-1:0]  song_position_q24;
   modport source(output valid, midi_byte, byte_valid, last, transport_state,
                  song_position_q24, input ready);
   modport sink(input valid, midi_byte, byte_valid, last, transport_state,
                song_position_q24, output ready);
endinterface

interface mctg_csr_if;
   import mctg_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

>>> hdl/midi_clock_transport_generator.sv
// ----------------------------------------------------------------------------
// midi_clock_transport_generator
// MIDI transport and 24-ppqn beat clock generator, run by a microcoded
// sequencer over a shared restoring divider.
//
// req_chan takes one command per item: advance, play, stop, pause, record,
// locate. rsp_chan returns one or more result items per command, the final
// one flagged by last; a command that sends no MIDI byte returns a single
// status-only item. csr_chan writes tempo, sample rate and clock enable; it
// is always ready; the user is to write it only while the block is idle,
// which the block itself does not enforce. An advance while running
// multiplies, loads the bit-serial divider for beats and pulses, divides,
// adds up position and pulse phase and then sends its 0xF8 bytes. One item at
// a time; the next is taken once the sequencer is back at its idle step, even
// if the last result still waits in the output register.
// Reset clears the transport to stopped, position and pulse phase to zero
// and the registers to their defaults. When rsp_chan stalls, the sequencer
// holds at its emit step until the output register frees.
// ----------------------------------------------------------------------------
module midi_clock_transport_generator #(
   parameter int MAX_BLOCK     = 1024,
   parameter int FRACTION_BITS = 40
) (
   input logic        clock,
   input logic        reset,
   mctg_req_if.sink   req_chan,
   mctg_rsp_if.source rsp_chan,
   mctg_csr_if.sink   csr_chan
);
   import mctg_pkg::*;

   // Datapath widths
   localparam int NB     = $clog2(MAX_BLOCK + 1);           // saturated sample count
   localparam int NW     = (NB > COUNT_W) ? NB : COUNT_W;    // width to compare count
   localparam int PROD_W = TEMPO_W + NB;                     // tempo * samples
   localparam int NUM_W  = PROD_W + 5;                       // times 24 pulses
   localparam int QW     = NUM_W + FRACTION_BITS;            // quotient bits
   localparam int CNT_W  = $clog2(QW);
   localparam int INT_W  = QW + 1 - FRACTION_BITS;           // whole pulses after add
   localparam int POS_SHIFT = FRACTION_BITS - SONG_FRAC;
   localparam int WIDE_W = POS_W + 8;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   upc_type                upc_ff, upc_in;
   logic [COUNT_W-1:0]     n_ff, n_in;
   logic [LOC_W-1:0]       loc_ff, loc_in;
   logic [TEMPO_W-1:0]     tempo_ff, tempo_in;
   logic [RATE_W-1:0]      rate_ff, rate_in;
   logic                   clk_en_ff, clk_en_in;
   mode_type               mode_ff, mode_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [FRACTION_BITS-1:0] phase_ff, phase_in;
   logic [DEN_W-1:0]       den_ff, den_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [QW-1:0]          qp_ff, qp_in;       // pulse lane: numerator, then quotient
   logic [QW-1:0]          qb_ff, qb_in;       // beat lane
   logic [DEN_W-1:0]       remp_ff, remp_in;
   logic [DEN_W-1:0]       remb_ff, remb_in;
   logic [CNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic [PCNT_W-1:0]      pcnt_ff, pcnt_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]      rsp_byte_ff, rsp_byte_in;
   logic                   rsp_bv_ff, rsp_bv_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [STATE_W-1:0]     rsp_state_ff, rsp_state_in;
   logic [SONG_W-1:0]      rsp_song_ff, rsp_song_in;

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   ucode_type uw;
   logic      is_emit;
   logic      out_free;
   logic      go;
   logic      taken;
   logic      running;

   assign uw       = ucode_rom(upc_ff);
   assign is_emit  = (uw.emit != EM_NONE);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign running  = (mode_ff == MODE_PLAYING) || (mode_ff == MODE_RECORDING);

   // Take a command only at the idle step
   assign req_chan.ready = (uw.act == ACT_ACCEPT);
   assign csr_chan.ready = 1'b1;

   always_comb begin
      if (is_emit) begin
         go = out_free;                 // hold until the output register frees
      end else if (uw.act == ACT_ACCEPT) begin
         go = req_chan.valid;
      end else begin
         go = 1'b1;
      end
   end

   always_comb begin
      case (uw.cond)
         BR_NEXT:       taken = 1'b0;
         BR_ALWAYS:     taken = 1'b1;
         BR_DISPATCH:   taken = 1'b1;
         BR_DIV_MORE:   taken = (div_cnt_ff != '0);
         BR_PULSE_MORE: taken = (pcnt_ff > PCNT_W'(1));
         BR_NO_PULSE:   taken = (pcnt_ff == '0);
         BR_NOT_RUN:    taken = !running;
         BR_SKIP_PLAY:  taken = (mode_ff == MODE_PLAYING);
         BR_SKIP_STOP:  taken = (mode_ff == MODE_STOPPED);
         BR_NO_EN:      taken = !clk_en_ff;
         default:       taken = 1'b0;
      endcase
   end

   always_comb begin
      upc_in = upc_ff;
      if (go) begin
         if (uw.cond == BR_DISPATCH) begin
            upc_in = dispatch(req_chan.cmd);
         end else if (taken) begin
            upc_in = uw.target;
         end else begin
            upc_in = upc_ff + upc_type'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------------
   logic [TEMPO_W-1:0] t_cl;
   logic [RATE_W-1:0]  r_cl;
   logic [NW-1:0]      n_ext;
   logic [NB-1:0]      n_sat;
   logic [NUM_W-1:0]   num_p;
   logic [DEN_W:0]     remp_sh, remb_sh, remp_sub, remb_sub;
   logic               gep, geb;
   logic [QW:0]        psum;
   logic [INT_W-1:0]   pint;
   logic [PCNT_W-1:0]  pcnt_new;

   // Clamp registers to their working range
   assign t_cl = (tempo_ff < TEMPO_MIN) ? TEMPO_MIN :
                 (tempo_ff > TEMPO_MAX) ? TEMPO_MAX : tempo_ff;
   assign r_cl = (rate_ff < RATE_MIN) ? RATE_MIN :
                 (rate_ff > RATE_MAX) ? RATE_MAX : rate_ff;
   assign n_ext = NW'(n_ff);
   assign n_sat = (n_ext > NW'(MAX_BLOCK)) ? NB'(MAX_BLOCK) : NB'(n_ext);

   // 24 * x as (16 + 8) * x
   assign num_p = NUM_W'({prod_ff, 4'b0000}) + NUM_W'({prod_ff, 3'b000});

   // One restoring step per lane, both against the same divisor
   assign remp_sh  = {remp_ff, qp_ff[QW-1]};
   assign remb_sh  = {remb_ff, qb_ff[QW-1]};
   assign remp_sub = remp_sh - {1'b0, den_ff};
   assign remb_sub = remb_sh - {1'b0, den_ff};
   assign gep      = (remp_sh >= {1'b0, den_ff});
   assign geb      = (remb_sh >= {1'b0, den_ff});

   // New phase and whole pulses crossed, capped per block
   assign psum     = (QW+1)'(qp_ff) + (QW+1)'(phase_ff);
   assign pint     = psum[QW:FRACTION_BITS];
   assign pcnt_new = (pint > INT_W'(MAX_PULSES)) ? MAX_PULSES : PCNT_W'(pint);

   always_comb begin
      n_in       = n_ff;
      loc_in     = loc_ff;
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      phase_in   = phase_ff;
      den_in     = den_ff;
      prod_in    = prod_ff;
      qp_in      = qp_ff;
      qb_in      = qb_ff;
      remp_in    = remp_ff;
      remb_in    = remb_ff;
      div_cnt_in = div_cnt_ff;
      pcnt_in    = pcnt_ff;
      if (go) begin
         case (uw.act)
            ACT_ACCEPT: begin
               n_in   = req_chan.sample_count;
               loc_in = req_chan.locate_beats_q8;
            end
            ACT_MUL: begin
               den_in  = DEN_W'(MILLI_PER_MINUTE) * DEN_W'(r_cl);
               prod_in = PROD_W'(t_cl) * PROD_W'(n_sat);
            end
            ACT_LOAD: begin
               qp_in      = {num_p, {FRACTION_BITS{1'b0}}};
               qb_in      = {NUM_W'(prod_ff), {FRACTION_BITS{1'b0}}};
               remp_in    = '0;
               remb_in    = '0;
               div_cnt_in = CNT_W'(QW - 1);
            end
            ACT_DIV: begin
               remp_in    = gep ? remp_sub[DEN_W-1:0] : remp_sh[DEN_W-1:0];
               remb_in    = geb ? remb_sub[DEN_W-1:0] : remb_sh[DEN_W-1:0];
               qp_in      = {qp_ff[QW-2:0], gep};
               qb_in      = {qb_ff[QW-2:0], geb};
               div_cnt_in = div_cnt_ff - CNT_W'(1);
            end
            ACT_ACC: begin
               pos_in = pos_ff + POS_W'(qb_ff);
               if (clk_en_ff) begin
                  phase_in = psum[FRACTION_BITS-1:0];
                  pcnt_in  = pcnt_new;
               end else begin
                  pcnt_in  = '0;
               end
            end
            ACT_PLAY:   mode_in = MODE_PLAYING;
            ACT_STOP: begin
               mode_in = MODE_STOPPED;
               pos_in  = '0;
            end
            ACT_PAUSE:  mode_in = MODE_PAUSED;
            ACT_RECORD: mode_in = MODE_RECORDING;
            ACT_LOCATE: pos_in = POS_W'(loc_ff) << (FRACTION_BITS - LOC_FRAC);
            default: ;
         endcase
         // Count down clock bytes as they go out
         if (uw.emit == EM_CLOCK) begin
            pcnt_in = pcnt_ff - PCNT_W'(1);
         end
      end
      // Enabling the clock output restarts the pulse phase
      if (csr_chan.valid && (csr_chan.index == REG_CLK_EN) && csr_chan.data[0]) begin
         phase_in = '0;
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_comb begin
      tempo_in  = tempo_ff;
      rate_in   = rate_ff;
      clk_en_in = clk_en_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_TEMPO:  tempo_in  = csr_chan.data[TEMPO_W-1:0];
            REG_RATE:   rate_in   = csr_chan.data[RATE_W-1:0];
            REG_CLK_EN: clk_en_in = csr_chan.data[0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   logic [BYTE_W-1:0] emit_byte;
   logic [WIDE_W-1:0] pos_wide;
   logic [13:0]       spp;

   assign spp      = {loc_ff[LOC_W-1:LOC_FRAC], 2'b00};  // whole beats in sixteenths
   assign pos_wide = {8'd0, pos_ff};

   always_comb begin
      case (uw.emit)
         EM_CLOCK:  emit_byte = MIDI_CLOCK;
         EM_START:  emit_byte = MIDI_START;
         EM_STOP:   emit_byte = MIDI_STOP;
         EM_SPP:    emit_byte = MIDI_SPP;
         EM_SPP_LO: emit_byte = {1'b0, spp[6:0]};
         EM_SPP_HI: emit_byte = {1'b0, spp[13:7]};
         default:   emit_byte = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_bv_in    = rsp_bv_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_state_in = rsp_state_ff;
      rsp_song_in  = rsp_song_ff;
      if (is_emit && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_bv_in    = (uw.emit != EM_STATUS);
         rsp_last_in  = uw.last || ((uw.emit == EM_CLOCK) && (pcnt_ff == PCNT_W'(1)));
         rsp_state_in = STATE_W'(mode_ff);
         rsp_song_in  = pos_wide[POS_SHIFT +: SONG_W];
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.midi_byte         = rsp_byte_ff;
   assign rsp_chan.byte_valid        = rsp_bv_ff;
   assign rsp_chan.last              = rsp_last_ff;
   assign rsp_chan.transport_state   = rsp_state_ff;
   assign rsp_chan.song_position_q24 = rsp_song_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UPC_IDLE;
         tempo_ff     <= TEMPO_RESET;
         rate_ff      <= RATE_RESET;
         clk_en_ff    <= 1'b0;
         mode_ff      <= MODE_STOPPED;
         pos_ff       <= '0;
         phase_ff     <= '0;
         div_cnt_ff   <= '0;
         pcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         tempo_ff     <= tempo_in;
         rate_ff      <= rate_in;
         clk_en_ff    <= clk_en_in;
         mode_ff      <= mode_in;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         div_cnt_ff   <= div_cnt_in;
         pcnt_ff      <= pcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      loc_ff       <= loc_in;
      den_ff       <= den_in;
      prod_ff      <= prod_in;
      qp_ff        <= qp_in;
      qb_ff        <= qb_in;
      remp_ff      <= remp_in;
      remb_ff      <= remb_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_bv_ff    <= rsp_bv_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_state_ff <= rsp_state_in;
      rsp_song_ff  <= rsp_song_in;
   end

endmodule

>>> hdl/mctg_checker.sv
// ----------------------------------------------------------------------------
// mctg_checker
// Port-level checks of the transport generator, bound to the top level.
// ----------------------------------------------------------------------------
module mctg_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [mctg_pkg::BYTE_W-1:0]    midi_byte,
   input logic                           byte_valid,
   input logic                           last
);
   import mctg_pkg::*;

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(midi_byte) && $stable(last))
      else $error("result changed while stalled");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One command at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command taken while busy");

   // Status-only result closes its command and carries no byte
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !byte_valid |-> (midi_byte == '0) && last)
      else $error("malformed status-only result");

   // Song position pointer status is followed by its data bytes
   a_spp_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && byte_valid && (midi_byte == MIDI_SPP) |-> !last)
      else $error("song position pointer cut short");

endmodule

bind midi_clock_transport_generator mctg_checker u_mctg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .midi_byte  (rsp_chan.midi_byte),
   .byte_valid (rsp_chan.byte_valid),
   .last       (rsp_chan.last)
);

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb - MIDI beat clock transport generator testbench
// Drives transport commands and register writes into the generator, predicts
// every MIDI byte and status item in a scoreboard that tracks mode, position
// and pulse phase, and checks each result item in order, under random idling
// on both channels and one long receiver stall.
// ----------------------------------------------------------------------------
module tb;
   import mctg_pkg::*;

   localparam int BLOCK_LIMIT     = 1024;
   localparam int FRAC_BITS       = 40;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_ITEMS     = 42;
   localparam int QUIET_PHASE     = 2;
   localparam int PRESSURE_PHASE  = 4;
   localparam int SILENT_PHASE    = 6;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 100;
   localparam int MAX_REPORTS     = 40;

   localparam logic [63:0] ONE_PULSE = 64'd1 << FRAC_BITS;

   // Codes the package leaves unnamed
   localparam logic [CMD_W-1:0]     CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0]     CMD_SPARE_HI = 3'd7;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE    = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0]  midi_byte;
      logic               byte_valid;
      logic               last;
      logic [STATE_W-1:0] state;
      logic [SONG_W-1:0]  song_pos;
   } midi_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of registers and transport state, queue of the
   // result items still owed by the block.
   // -------------------------------------------------------------------------
   class midi_transport_checker_type;
      logic [TEMPO_W-1:0] tempo;
      logic [RATE_W-1:0]  rate;
      logic               clock_enable;
      mode_type           mode;
      logic [POS_W-1:0]   position;
      logic [63:0]        phase;
      midi_result_type    due_results[$];
      int                 errors;
      int                 results_seen;
      int                 clock_bytes;
      int                 register_writes;
      int                 command_hits[8];

      function new();
         tempo           = TEMPO_RESET;
         rate            = RATE_RESET;
         clock_enable    = 1'b0;
         mode            = MODE_STOPPED;
         position        = '0;
         phase           = '0;
         errors          = 0;
         results_seen    = 0;
         clock_bytes     = 0;
         register_writes = 0;
         foreach (command_hits[i]) command_hits[i] = 0;
      endfunction

      function int outstanding();
         return due_results.size();
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         register_writes++;
         case (index)
            REG_TEMPO: tempo = data[TEMPO_W-1:0];
            REG_RATE:  rate = data[RATE_W-1:0];
            REG_CLK_EN: begin
               clock_enable = data[0];
               if (data[0]) phase = '0;
            end
            default: ;
         endcase
      endfunction

      // floor(num * 2^FRAC_BITS / den)
      function logic [63:0] scaled_quotient(logic [127:0] num, logic [63:0] den);
         logic [127:0] q;
         q = (num << FRAC_BITS) / {64'd0, den};
         return q[63:0];
      endfunction

      function void predict_command(logic [CMD_W-1:0] cmd, logic [COUNT_W-1:0] count,
                                    logic [LOC_W-1:0] loc);
         logic [BYTE_W-1:0]  bytes[$];
         logic [TEMPO_W-1:0] t;
         logic [RATE_W-1:0]  r;
         logic [COUNT_W-1:0] n;
         logic [63:0]        den;
         logic [63:0]        acc;
         logic [13:0]        sixteenths;
         midi_result_type    res;
         command_hits[cmd]++;
         case (cmd)
            CMD_ADVANCE: begin
               if (mode == MODE_PLAYING || mode == MODE_RECORDING) begin
                  t = tempo;
                  if (t < TEMPO_MIN) t = TEMPO_MIN;
                  if (t > TEMPO_MAX) t = TEMPO_MAX;
                  r = rate;
                  if (r < RATE_MIN) r = RATE_MIN;
                  if (r > RATE_MAX) r = RATE_MAX;
                  n = (count > BLOCK_LIMIT) ? COUNT_W'(BLOCK_LIMIT) : count;
                  den = 64'(MILLI_PER_MINUTE) * 64'(r);
                  if (clock_enable) begin
                     acc = phase + scaled_quotient(128'(t) * 128'(24) * 128'(n), den);
                     while (acc >= ONE_PULSE && bytes.size() < int'(MAX_PULSES)) begin
                        bytes.push_back(MIDI_CLOCK);
                        acc -= ONE_PULSE;
                     end
                     phase = acc & (ONE_PULSE - 64'd1);
                  end
                  position += scaled_quotient(128'(t) * 128'(n), den);
               end
            end
            CMD_PLAY: begin
               if (mode != MODE_PLAYING) begin
                  mode = MODE_PLAYING;
                  if (clock_enable) bytes.push_back(MIDI_START);
               end
            end
            CMD_STOP: begin
               if (mode != MODE_STOPPED) begin
                  mode = MODE_STOPPED;
                  position = '0;
                  if (clock_enable) bytes.push_back(MIDI_STOP);
               end
            end
            CMD_PAUSE: begin
               mode = MODE_PAUSED;
               if (clock_enable) bytes.push_back(MIDI_STOP);
            end
            CMD_RECORD: begin
               mode = MODE_RECORDING;
               if (clock_enable) bytes.push_back(MIDI_START);
            end
            CMD_LOCATE: begin
               position = 64'(loc) << (FRAC_BITS - LOC_FRAC);
               if (clock_enable) begin
                  sixteenths = {loc[LOC_W-1:LOC_FRAC], 2'b00};
                  bytes.push_back(MIDI_SPP);
                  bytes.push_back({1'b0, sixteenths[6:0]});
                  bytes.push_back({1'b0, sixteenths[13:7]});
               end
            end
            default: ;
         endcase
         res.state    = mode;
         res.song_pos = position[FRAC_BITS-SONG_FRAC +: SONG_W];
         if (bytes.size() == 0) begin
            res.midi_byte  = '0;
            res.byte_valid = 1'b0;
            res.last       = 1'b1;
            due_results.push_back(res);
         end
         for (int i = 0; i < bytes.size(); i++) begin
            res.midi_byte  = bytes[i];
            res.byte_valid = 1'b1;
            res.last       = (i == bytes.size() - 1);
            due_results.push_back(res);
         end
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("ERROR @%0t result %0d: %s", $time, results_seen, what);
      endtask

      task check_result(logic [BYTE_W-1:0] midi_byte, logic byte_valid, logic last,
                        logic [STATE_W-1:0] state, logic [SONG_W-1:0] song_pos);
         midi_result_type want;
         results_seen++;
         if (byte_valid === 1'b1 && midi_byte === MIDI_CLOCK) clock_bytes++;
         if (due_results.size() == 0) begin
            report_mismatch("result item with nothing expected");
            return;
         end
         want = due_results.pop_front();
         if (midi_byte !== want.midi_byte)
            report_mismatch($sformatf("midi_byte %h, expected %h", midi_byte, want.midi_byte));
         if (byte_valid !== want.byte_valid)
            report_mismatch($sformatf("byte_valid %b, expected %b",
                                      byte_valid, want.byte_valid));
         if (last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", last, want.last));
         if (state !== want.state)
            report_mismatch($sformatf("transport_state %0d, expected %0d",
                                      state, want.state));
         if (song_pos !== want.song_pos)
            report_mismatch($sformatf("song_position_q24 %h, expected %h",
                                      song_pos, want.song_pos));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the block under test
   // -------------------------------------------------------------------------
   logic clock;
   logic reset;
   bit   stall_request;   // ask the receiver for one long hold-off
   bit   quiet_phase;     // no idling on either side

   midi_transport_checker_type sb;

   mctg_req_if req_chan();
   mctg_rsp_if rsp_chan();
   mctg_csr_if csr_chan();

   midi_clock_transport_generator #(
      .MAX_BLOCK(BLOCK_LIMIT),
      .FRACTION_BITS(FRAC_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: sized for every item hitting the clock byte cap with every
   // result waiting out the longest receiver gap, several times over.
   initial begin
      #25000000;
      $display("midi_clock_transport_generator: mismatch");
      $finish;
   end

   // Sample all handshakes at the rising edge; register writes and commands
   // feed the scoreboard, results are checked against it.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready)
            sb.write_register(csr_chan.index, csr_chan.data);
         if (req_chan.valid && req_chan.ready)
            sb.predict_command(req_chan.cmd, req_chan.sample_count, req_chan.locate_beats_q8);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_result(rsp_chan.midi_byte, rsp_chan.byte_valid, rsp_chan.last,
                            rsp_chan.transport_state, rsp_chan.song_position_q24);
      end
   end

   // Mostly no gap, some short ones, a few long ones.
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Receiver: random ready with gaps, plus the long hold-off on request.
   initial begin
      int hold;
      hold = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            // hold off long enough that the block fills up and stalls its input
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            stall_request = 1'b0;
         end else if (quiet_phase) begin
            hold = 0;
            rsp_chan.ready <= 1'b1;
         end else if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            hold--;
         end else if ($urandom_range(0, 4) == 0) begin
            hold = idle_length();
            if (hold == 0) begin
               rsp_chan.ready <= 1'b1;
            end else begin
               rsp_chan.ready <= 1'b0;
               hold--;
            end
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Offer one command item; valid stays high after acceptance so that a
   // following item without gap goes back to back.
   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [COUNT_W-1:0] count,
                               input logic [LOC_W-1:0] loc);
      int gap;
      gap = quiet_phase ? 0 : idle_length();
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid           <= 1'b1;
      req_chan.cmd             <= cmd;
      req_chan.sample_count    <= count;
      req_chan.locate_beats_q8 <= loc;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Drop valid, wait for every owed result, then let the sequencer settle.
   task automatic settle_block();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.outstanding() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Block sizes: empty, full, oversized (saturates) and ordinary.
   function automatic logic [COUNT_W-1:0] random_count();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return COUNT_W'(BLOCK_LIMIT);
         2: return COUNT_W'($urandom_range(BLOCK_LIMIT + 1, 2047));
         default: return COUNT_W'($urandom_range(1, BLOCK_LIMIT));
      endcase
   endfunction

   // Tempo data, including clamped values below and above the legal range.
   function automatic logic [CSR_DATA_W-1:0] random_tempo();
      case ($urandom_range(0, 5))
         0: return CSR_DATA_W'(TEMPO_MIN);
         1: return CSR_DATA_W'(TEMPO_MAX);
         2: return CSR_DATA_W'($urandom);
         3: return CSR_DATA_W'($urandom_range(0, TEMPO_MIN - 1));
         default: return CSR_DATA_W'($urandom_range(60000, 240000));
      endcase
   endfunction

   // Rate data; upper data bits beyond the register width are dropped.
   function automatic logic [CSR_DATA_W-1:0] random_rate();
      case ($urandom_range(0, 5))
         0: return CSR_DATA_W'(RATE_MIN);
         1: return CSR_DATA_W'(RATE_MAX);
         2: return CSR_DATA_W'($urandom);
         3: return CSR_DATA_W'($urandom_range(0, RATE_MIN - 1));
         default: return CSR_DATA_W'($urandom_range(22050, 96000));
      endcase
   endfunction

   // Mostly a running transport fed with advances; transport changes,
   // locates and spare codes mixed in.
   function automatic logic [CMD_W-1:0] random_cmd();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return CMD_ADVANCE;
      if (pick < 65) return CMD_PLAY;
      if (pick < 71) return CMD_STOP;
      if (pick < 77) return CMD_PAUSE;
      if (pick < 85) return CMD_RECORD;
      if (pick < 96) return CMD_LOCATE;
      if (pick < 98) return CMD_SPARE_LO;
      return CMD_SPARE_HI;
   endfunction

   task automatic run_random_phase(input int index);
      csr_write(REG_TEMPO, (index == PRESSURE_PHASE) ? CSR_DATA_W'(TEMPO_MAX) : random_tempo());
      csr_write(REG_RATE, (index == PRESSURE_PHASE) ? CSR_DATA_W'(RATE_MIN) : random_rate());
      if (index % 3 == 0) csr_write(REG_SPARE, CSR_DATA_W'($urandom));
      // bit 0 alone enables the clock output; upper bits are don't-care
      csr_write(REG_CLK_EN, (index == SILENT_PHASE) ? 20'hFFFFE : CSR_DATA_W'(1));
      quiet_phase = (index == QUIET_PHASE);
      if (index == PRESSURE_PHASE) begin
         // start running, then hold the receiver off while items keep coming
         stall_request = 1'b1;
         send_command(CMD_PLAY, random_count(), LOC_W'($urandom));
      end
      repeat (PHASE_ITEMS)
         send_command(random_cmd(), random_count(), LOC_W'($urandom));
      settle_block();
      quiet_phase = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      stall_request            = 1'b0;
      quiet_phase              = 1'b0;
      reset                    = 1'b1;
      req_chan.valid           = 1'b0;
      req_chan.cmd             = CMD_ADVANCE;
      req_chan.sample_count    = '0;
      req_chan.locate_beats_q8 = '0;
      csr_chan.valid           = 1'b0;
      csr_chan.index           = REG_TEMPO;
      csr_chan.data            = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset defaults, clock output off: every item is status only.
      send_command(CMD_ADVANCE, 11'd16, '0);
      send_command(CMD_PLAY, '0, '0);
      send_command(CMD_ADVANCE, 11'd1024, '0);
      send_command(CMD_LOCATE, '0, 20'h00180);
      settle_block();

      // Clock output on: transport edges, ignored repeats, block extremes,
      // advance while paused, locate extremes and the spare codes.
      csr_write(REG_CLK_EN, 20'd1);
      send_command(CMD_STOP, '0, '0);
      send_command(CMD_STOP, '0, '0);
      send_command(CMD_PLAY, '0, '0);
      send_command(CMD_PLAY, '0, '0);
      send_command(CMD_ADVANCE, 11'd0, '0);
      send_command(CMD_ADVANCE, 11'd1, '0);
      send_command(CMD_ADVANCE, 11'd1024, '0);
      send_command(CMD_ADVANCE, 11'h7FF, '0);
      send_command(CMD_PAUSE, '0, '0);
      send_command(CMD_ADVANCE, 11'd300, '0);
      send_command(CMD_PAUSE, '0, '0);
      send_command(CMD_RECORD, '0, '0);
      send_command(CMD_ADVANCE, 11'd700, '0);
      send_command(CMD_LOCATE, 11'h7FF, 20'hFFFFF);
      send_command(CMD_LOCATE, '0, '0);
      send_command(CMD_LOCATE, '0, LOC_W'($urandom));
      send_command(CMD_SPARE_LO, 11'h7FF, 20'hFFFFF);
      send_command(CMD_SPARE_HI, 11'h7FF, 20'hFFFFF);
      settle_block();

      // Fastest pulse rate: all-ones tempo and zero rate clamp to the limits.
      csr_write(REG_TEMPO, 20'hFFFFF);
      csr_write(REG_RATE, 20'h00000);
      csr_write(REG_SPARE, 20'hFFFFF);
      csr_write(REG_CLK_EN, 20'hFFFFF);
      send_command(CMD_ADVANCE, 11'd1024, '0);
      send_command(CMD_ADVANCE, 11'd1024, '0);
      settle_block();

      // Slowest pulse rate: zero tempo and an oversized rate clamp the other way.
      csr_write(REG_TEMPO, 20'h00000);
      csr_write(REG_RATE, 20'hFFFFF);
      send_command(CMD_ADVANCE, 11'h7FF, '0);
      settle_block();

      for (int p = 0; p < RANDOM_PHASES; p++)
         run_random_phase(p);

      // Hold for stray items after the last expected one.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.outstanding() != 0)
         sb.report_mismatch($sformatf("%0d result items never arrived", sb.outstanding()));

      $display("commands: advance %0d, play %0d, stop %0d, pause %0d, record %0d,",
               sb.command_hits[CMD_ADVANCE], sb.command_hits[CMD_PLAY],
               sb.command_hits[CMD_STOP], sb.command_hits[CMD_PAUSE],
               sb.command_hits[CMD_RECORD]);
      $display("locate %0d, spare %0d; checked %0d result items (%0d clock bytes)",
               sb.command_hits[CMD_LOCATE],
               sb.command_hits[CMD_SPARE_LO] + sb.command_hits[CMD_SPARE_HI],
               sb.results_seen, sb.clock_bytes);
      $display("over %0d register writes, %0d errors", sb.register_writes, sb.errors);
      if (sb.errors == 0) begin
         $display("midi_clock_transport_generator: match");
      end else begin
         $display("midi_clock_transport_generator: mismatch");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/mctg_pkg.sv
hdl/mctg_if.sv
hdl/midi_clock_transport_generator.sv
hdl/mctg_checker.sv
tb/sv/tb.sv
